### hdl/oal_pkg.sv
// Shared widths, codes and controller/datapath interface types of the ordered list.
package oal_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int START_W = 7;
  localparam int FPOS_W  = 7;
  localparam int COUNT_W = 7;

  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_FIELDS_W  = OP_W + POS_W + VAL_W + START_W;
  localparam int OUT_FIELDS_W = 1 + VAL_W + FPOS_W + COUNT_W + 2;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE      = 3'd1;
  localparam logic [OP_W-1:0] OP_READ        = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH      = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH_FROM = 3'd4;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VAL
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT_M1,
    IDX_POS_M1,
    IDX_START,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef struct packed {
    logic    load;
    logic    mem_rd;
    wr_sel_t wr_sel;
    idx_op_t idx_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cap_data;
    logic    set_ok;
    logic    set_found;
    logic    out_load;
  } oal_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_ok;
    logic            ins_append;
    logic            rr_ok;
    logic            search_go;
    logic            idx_at_pos;
    logic            idx_last;
    logic            match;
  } oal_status_t;

endpackage

### hdl/oal_datapath.sv
// Datapath of the ordered list: request capture, entry memory, index, count and result registers.
module oal_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [oal_pkg::IN_TDATA_W-1:0] in_tdata,
  input  oal_pkg::oal_cmd_t              cmd,
  output oal_pkg::oal_status_t           status,
  output logic [oal_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import oal_pkg::*;

  logic [OP_W-1:0]    op_r;
  logic [POS_W-1:0]   pos_r;
  logic [DATA_W-1:0]  val_r;
  logic [START_W-1:0] start_r;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [ADDR_W-1:0]  idx_r;
  logic [ADDR_W-1:0]  idx_nxt;

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rdata_r;
  logic [ADDR_W-1:0]  waddr;
  logic [DATA_W-1:0]  wdata;

  logic               res_ok_r;
  logic [DATA_W-1:0]  res_data_r;
  logic [FPOS_W-1:0]  res_found_r;

  logic               out_ok_r;
  logic [VAL_W-1:0]   out_data_r;
  logic [FPOS_W-1:0]  out_found_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_empty_r;
  logic               out_full_r;

  logic [CMP_W-1:0]   cnt_x;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   idx_x;
  logic [CMP_W-1:0]   start_x;
  logic [CMP_W-1:0]   idx_p1_x;

  assign cnt_x    = CMP_W'(count_r);
  assign pos_x    = CMP_W'(pos_r);
  assign idx_x    = CMP_W'(idx_r);
  assign start_x  = (op_r == OP_SEARCH_FROM) ? CMP_W'(start_r) : '0;
  assign idx_p1_x = idx_x + CMP_W'(1);

  always_comb begin
    status.op         = op_r;
    status.ins_ok     = (cnt_x < CMP_W'(DEPTH)) && (pos_x != '0) &&
                        (pos_x <= cnt_x + CMP_W'(1));
    status.ins_append = (pos_x == cnt_x + CMP_W'(1));
    status.rr_ok      = (pos_x != '0) && (pos_x <= cnt_x);
    status.search_go  = (start_x < cnt_x);
    status.idx_at_pos = (idx_p1_x == pos_x);
    status.idx_last   = (idx_p1_x == cnt_x);
    status.match      = (rdata_r == val_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tdata[OP_W-1:0];
      pos_r   <= in_tdata[OP_W +: POS_W];
      val_r   <= DATA_W'(signed'(in_tdata[OP_W+POS_W +: VAL_W]));
      start_r <= in_tdata[OP_W+POS_W+VAL_W +: START_W];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    case (cmd.idx_op)
      IDX_HOLD:   idx_nxt = idx_r;
      IDX_CNT_M1: idx_nxt = ADDR_W'(count_r - CNT_W'(1));
      IDX_POS_M1: idx_nxt = ADDR_W'(pos_r - POS_W'(1));
      IDX_START:  idx_nxt = ADDR_W'(start_x);
      IDX_INC:    idx_nxt = idx_r + ADDR_W'(1);
      IDX_DEC:    idx_nxt = idx_r - ADDR_W'(1);
      default:    idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    waddr = idx_r;
    wdata = rdata_r;
    case (cmd.wr_sel)
      WR_UP:   waddr = idx_r + ADDR_W'(1);
      WR_DOWN: waddr = idx_r - ADDR_W'(1);
      WR_VAL: begin
        waddr = ADDR_W'(pos_r - POS_W'(1));
        wdata = val_r;
      end
      default: waddr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok_r    <= 1'b0;
      res_data_r  <= '0;
      res_found_r <= '0;
    end else begin
      if (cmd.set_ok || cmd.set_found) begin
        res_ok_r <= 1'b1;
      end
      if (cmd.cap_data) begin
        res_data_r <= rdata_r;
      end
      if (cmd.set_found) begin
        res_found_r <= FPOS_W'(idx_p1_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r    <= res_ok_r;
      out_data_r  <= VAL_W'(signed'(res_data_r));
      out_found_r <= res_found_r;
      out_count_r <= COUNT_W'(count_r);
      out_empty_r <= (count_r == '0);
      out_full_r  <= (cnt_x == CMP_W'(DEPTH));
    end
  end

  assign out_tdata = OUT_TDATA_W'({out_full_r, out_empty_r, out_count_r,
                                   out_found_r, out_data_r, out_ok_r});

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && (cmd.wr_sel != WR_NONE)))
    else $error("entry memory read and written in one cycle");

  a_grow_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (CMP_W'(count_r) < CMP_W'(DEPTH)) && !cmd.cnt_dec)
    else $error("insert into a full list");

  a_shrink_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (count_r != '0) && !cmd.cnt_inc)
    else $error("remove from an empty list");

endmodule

### hdl/oal_ctrl.sv
// Controller of the ordered list: sequences shifts, reads and searches over the entry memory.
module oal_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  oal_pkg::oal_status_t status,
  output oal_pkg::oal_cmd_t    cmd
);
  import oal_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_SH  = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_RM_RD   = 4'd5;
  localparam logic [3:0] S_RM_CAP  = 4'd6;
  localparam logic [3:0] S_RM_SHRD = 4'd7;
  localparam logic [3:0] S_RM_SHWR = 4'd8;
  localparam logic [3:0] S_RD_RD   = 4'd9;
  localparam logic [3:0] S_RD_CAP  = 4'd10;
  localparam logic [3:0] S_SR_RD   = 4'd11;
  localparam logic [3:0] S_SR_CMP  = 4'd12;
  localparam logic [3:0] S_FINISH  = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_tvalid_r;
  logic       out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_FINISH;
        unique case (status.op) inside
          OP_INSERT: begin
            if (status.ins_ok) begin
              if (status.ins_append) begin
                state_nxt = S_INS_WR;
              end else begin
                cmd.idx_op = IDX_CNT_M1;
                state_nxt  = S_INS_RD;
              end
            end
          end
          OP_REMOVE: begin
            if (status.rr_ok) begin
              cmd.idx_op = IDX_POS_M1;
              state_nxt  = S_RM_RD;
            end
          end
          OP_READ: begin
            if (status.rr_ok) begin
              cmd.idx_op = IDX_POS_M1;
              state_nxt  = S_RD_RD;
            end
          end
          OP_SEARCH, OP_SEARCH_FROM: begin
            if (status.search_go) begin
              cmd.idx_op = IDX_START;
              state_nxt  = S_SR_RD;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_INS_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_INS_SH;
      end
      S_INS_SH: begin
        cmd.wr_sel = WR_UP;
        if (status.idx_at_pos) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_nxt  = S_INS_RD;
        end
      end
      S_INS_WR: begin
        cmd.wr_sel  = WR_VAL;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_RM_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_RM_CAP;
      end
      S_RM_CAP: begin
        cmd.cap_data = 1'b1;
        cmd.set_ok   = 1'b1;
        if (status.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_RM_SHRD;
        end
      end
      S_RM_SHRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_RM_SHWR;
      end
      S_RM_SHWR: begin
        cmd.wr_sel = WR_DOWN;
        if (status.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_RM_SHRD;
        end
      end
      S_RD_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_data = 1'b1;
        cmd.set_ok   = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_SR_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (status.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_FINISH;
        end else if (status.idx_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_SR_RD;
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == S_FINISH) && (!out_tvalid_r || out_tready))
    else $error("result register overwritten while held");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECIDE) && !in_tready)
    else $error("request accepted without starting work");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid && in_tready)
    else $error("finished request did not raise a result");

endmodule

### hdl/ordered_array_list.sv
// Top level of the ordered list: a bounded, position-addressed list of signed words.
//
// Requests enter on the in_ channel, one result per request leaves on the out_ channel;
// a request is taken when tvalid and tready are both high at a rising edge.
// in_tready is high only while no request is being worked on; a finished result
// waits in the output register, so the next request is taken while it is held.
// The single-port entry memory moves or compares one entry at a time, a read and then
// a write or compare for each: an insert shifts the entries from the last down to the
// position up by one and then writes the value; a remove reads and captures the entry,
// then shifts each later entry down by one; a read reads and captures the entry; a
// search compares entries from its start until a match or the last entry. A rejected
// request, or a search with nothing to scan, goes straight to the result. After each
// result the block returns to idle before the next request is taken.
// When out_tready is low the result holds and the block finishes its current request,
// then waits with that result until the held one is taken.
// Reset (rst_n low, synchronous) empties the list and drops any held result;
// entry contents are not cleared, as only written entries are ever read.
module ordered_array_list (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode[2:0], position[9:3], item_value[41:10], search_start[48:42], zero fill
  input  logic [oal_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ok[0], data_out[32:1], found_pos[39:33], count[46:40], is_empty[47],
  // is_full[48], zero fill
  output logic [oal_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import oal_pkg::*;

  oal_cmd_t    cmd;
  oal_status_t status;

  oal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  oal_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

### bench/tb.sv
// Self-checking testbench for the ordered list: directed and random requests against a predictor.
module tb;
  import oal_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   value;
    logic [START_W-1:0] start;
  } list_req_t;

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   data;
    logic [FPOS_W-1:0]  found_pos;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // opcode[2:0], position[9:3], item_value[41:10], search_start[48:42], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // ok[0], data_out[32:1], found_pos[39:33], count[46:40], is_empty[47],
  // is_full[48], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [DATA_W-1:0] list_words [DEPTH];
  int                list_count = 0;
  list_result_t      expected_results [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int deepest_list = 0;
  int full_results = 0;
  int search_hits = 0;
  int stall_cycles = 0;

  list_result_t got;
  list_result_t want;

  ordered_array_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic list_result_t apply_to_list(input list_req_t rq);
    list_result_t r;
    int           p;
    int           i;
    r = '0;
    p = rq.pos;
    case (rq.op) inside
      OP_INSERT: begin
        if (list_count < DEPTH && p >= 1 && p <= list_count + 1) begin
          for (i = list_count; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = rq.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (p >= 1 && p <= list_count) begin
          r.data = list_words[p-1];
          for (i = p - 1; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (p >= 1 && p <= list_count) begin
          r.data = list_words[p-1];
          r.ok = 1'b1;
        end
      end
      OP_SEARCH, OP_SEARCH_FROM: begin
        i = (rq.op == OP_SEARCH) ? 0 : int'(rq.start);
        while (i < list_count && r.found_pos == '0) begin
          if (list_words[i] == rq.value) r.found_pos = FPOS_W'(i + 1);
          i++;
        end
        r.ok = (r.found_pos != '0);
      end
      default: begin
      end
    endcase
    r.count    = COUNT_W'(list_count);
    r.is_empty = (list_count == 0);
    r.is_full  = (list_count == DEPTH);
    return r;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                              input logic [VAL_W-1:0] value, input int start);
    list_req_t rq;
    rq.op    = op;
    rq.pos   = POS_W'(pos);
    rq.value = value;
    rq.start = START_W'(start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({rq.start, rq.value, rq.pos, rq.op});
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_to_list(rq));
    requests_sent++;
    if (list_count > deepest_list) deepest_list = list_count;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                             input logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h (result %0d)",
                 name, exp_v, act_v, results_checked);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.ok        = out_tdata[0];
      got.data      = out_tdata[32:1];
      got.found_pos = out_tdata[39:33];
      got.count     = out_tdata[46:40];
      got.is_empty  = out_tdata[47];
      got.is_full   = out_tdata[48];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("ok", VAL_W'(want.ok), VAL_W'(got.ok));
        check_field("data_out", want.data, got.data);
        check_field("found_pos", VAL_W'(want.found_pos), VAL_W'(got.found_pos));
        check_field("count", VAL_W'(want.count), VAL_W'(got.count));
        check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
        check_field("is_full", VAL_W'(want.is_full), VAL_W'(got.is_full));
        if (want.is_full) full_results++;
        if (want.found_pos != '0) search_hits++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4, 5: return VAL_W'($urandom_range(8, 1));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_key();
    if (list_count > 0 && $urandom_range(99) < 60)
      return list_words[$urandom_range(list_count - 1)];
    return pick_value();
  endfunction

  function automatic int pick_position(input int limit);
    if (limit > 0 && $urandom_range(99) < 75) return $urandom_range(limit, 1);
    return $urandom_range(127);
  endfunction

  function automatic int pick_start();
    if ($urandom_range(99) < 70) return $urandom_range(list_count);
    return $urandom_range(127);
  endfunction

  task automatic test_empty_list();
    send_request(OP_READ, 1, '1, 0);
    send_request(OP_REMOVE, 1, '0, 0);
    send_request(OP_SEARCH, 0, '0, 0);
    send_request(OP_SEARCH_FROM, 0, '0, 0);
    send_request(OP_INSERT, 0, 32'h1234_5678, 0);
    send_request(OP_INSERT, 2, 32'h1234_5678, 0);
  endtask

  task automatic test_value_extremes();
    send_request(OP_INSERT, 1, 32'h8000_0000, 127);
    send_request(OP_INSERT, 2, 32'h7fff_ffff, 0);
    send_request(OP_INSERT, 1, '1, 0);
    send_request(OP_INSERT, 4, '0, 0);
    send_request(OP_INSERT, 127, 32'h5555_aaaa, 0);
    for (int p = 1; p <= 4; p++) send_request(OP_READ, p, '0, 0);
  endtask

  task automatic test_search();
    send_request(OP_SEARCH, 0, 32'h7fff_ffff, 0);
    send_request(OP_SEARCH, 0, 32'd5, 0);
    send_request(OP_SEARCH_FROM, 0, '1, 0);
    send_request(OP_SEARCH_FROM, 0, '1, 1);
    send_request(OP_SEARCH_FROM, 0, '0, 3);
    send_request(OP_SEARCH_FROM, 0, '0, 4);
    send_request(OP_SEARCH_FROM, 127, '0, 127);
  endtask

  task automatic test_remove();
    send_request(OP_REMOVE, 2, '0, 0);
    send_request(OP_REMOVE, 4, '0, 0);
    send_request(OP_REMOVE, 3, '0, 0);
    send_request(OP_READ, 127, '0, 0);
  endtask

  task automatic test_unused_opcodes();
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_request(OP_W'(op), 127, '1, 127);
  endtask

  task automatic test_fill_and_drain();
    while (list_count < DEPTH)
      send_request(OP_INSERT, $urandom_range(list_count + 1, 1), pick_value(), 0);
    send_request(OP_INSERT, 1, pick_value(), 0);
    send_request(OP_INSERT, DEPTH + 1, pick_value(), 0);
    send_request(OP_READ, DEPTH, '0, 0);
    send_request(OP_SEARCH, 0, list_words[DEPTH-1], 0);
    send_request(OP_SEARCH_FROM, 0, list_words[DEPTH-1], DEPTH - 1);
    send_request(OP_REMOVE, DEPTH + 1, '0, 0);
    while (list_count > 0)
      send_request(OP_REMOVE, $urandom_range(list_count, 1), '0, 0);
    send_request(OP_REMOVE, 1, '0, 0);
  endtask

  task automatic test_random_mix(input int n);
    int r;
    int fill_pct;
    int phase_offset;
    phase_offset = $urandom_range(1);
    for (int k = 0; k < n; k++) begin
      fill_pct = (((k / 100) + phase_offset) % 2) ? 8 : 92;
      r = $urandom_range(99);
      if (r < 5)
        send_request(OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                     $urandom_range(127), VAL_W'($urandom), $urandom_range(127));
      else if (r < 55 && $urandom_range(99) < fill_pct)
        send_request(OP_INSERT, pick_position(list_count + 1), pick_value(),
                     $urandom_range(127));
      else if (r < 55)
        send_request(OP_REMOVE, pick_position(list_count), VAL_W'($urandom),
                     $urandom_range(127));
      else if (r < 70)
        send_request(OP_READ, pick_position(list_count), VAL_W'($urandom),
                     $urandom_range(127));
      else if (r < 85)
        send_request(OP_SEARCH, $urandom_range(127), pick_key(), $urandom_range(127));
      else
        send_request(OP_SEARCH_FROM, $urandom_range(127), pick_key(), pick_start());
    end
  endtask

  initial begin
    tx_idle_pct = 23;
    rx_idle_pct = 75;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_value_extremes();
    test_search();
    test_remove();
    test_unused_opcodes();
    test_fill_and_drain();
    test_random_mix(250);
    wait_drain();
    tx_idle_pct = 75;
    rx_idle_pct = 23;
    test_random_mix(250);
    wait_drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mix(250);
    wait_drain();
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, mismatches);
    $display("deepest list %0d of %0d, %0d results at full, %0d search hits",
             deepest_list, DEPTH, full_results, search_hits);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
